@@ rtl/core/hsc_pkg.sv @@
// Shared types, constants and code-shape functions for the Hamming SEC codec.
package hsc_pkg;

   localparam int CODE_W = 63;
   localparam int DATA_W = 57;
   localparam int SYN_W  = 6;
   localparam int CFG_W  = 6;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // Register index in the CSR map (byte address / 4)
   localparam logic REG_DATA_BITS = 1'b0;

   localparam logic [CFG_W-1:0] DATA_BITS_RESET = CFG_W'(4);

   typedef enum logic {
      ACT_ENCODE = 1'b0,
      ACT_CHECK  = 1'b1
   } hsc_action_type;

   typedef struct packed {
      hsc_action_type    action;
      logic [CODE_W-1:0] word;
   } hsc_req_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_word;
      logic [DATA_W-1:0] data_word;
      logic              error_found;
      logic [SYN_W-1:0]  error_position;
      logic              uncorrectable;
   } hsc_rsp_type;

   // Smallest p with 2^p >= d + p + 1
   function automatic logic [2:0] parity_count(input logic [CFG_W-1:0] d);
      logic [2:0] p;
      p = 3'd0;
      for (int k = 0; k < 7; k++) begin
         if ((32'd1 << p) < (32'(d) + 32'(p) + 32'd1)) begin
            p = p + 3'd1;
         end
      end
      return p;
   endfunction

   // Largest data length whose code length fits in max_code
   function automatic logic [CFG_W-1:0] max_data_bits(input int max_code);
      logic [CFG_W-1:0] best;
      best = CFG_W'(1);
      for (int d = 1; d <= DATA_W; d++) begin
         if (d + int'(parity_count(CFG_W'(d))) <= max_code) begin
            best = CFG_W'(d);
         end
      end
      return best;
   endfunction

   function automatic logic is_pow2(input int pos);
      return (pos & (pos - 1)) == 0;
   endfunction

endpackage

@@ rtl/core/hamming_sec_codec.sv @@
// Top level of the Hamming single-error-correcting codec with CSR port.
//
// Usage: drive req_data and raise start; a word is taken at each rising edge
// with start high and busy low. busy is always low, so a word may be sent
// every cycle. Action ACT_ENCODE places the low data_bits bits of word into
// a codeword with even parity at the power-of-two positions. ACT_CHECK works
// out the syndrome of the codeword, flips the indicated bit when it lies in
// the code, flags a syndrome beyond the code as uncorrectable, and returns
// the corrected codeword with its data bits.
// Pipeline: rsp_valid rises at the edge after the accepting edge, with the
// result on rsp_data (input register, one pass of XOR trees and correction,
// result register).
// Throughput: one word per cycle. rsp_valid marks each result for exactly
// one cycle; the receiver has no way to hold it off.
// CSR: register data_bits (6 bits, reset 4) at byte address 0 of the APB
// port; change it only while no word is in flight.
// Reset: synchronous, clears the pipeline valid bits and reloads data_bits.
module hamming_sec_codec #(
   parameter int MAX_CODE_BITS = 63
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  hsc_pkg::hsc_req_type          req_data,
   output logic                          rsp_valid,
   output hsc_pkg::hsc_rsp_type          rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hsc_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [hsc_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [hsc_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import hsc_pkg::*;

   localparam logic [CFG_W-1:0] DATA_MAX = max_data_bits(MAX_CODE_BITS);

   logic [CFG_W-1:0]  data_bits_ff, data_bits_in;
   logic              req_valid_ff, req_valid_in;
   hsc_req_type       req_ff, req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   hsc_rsp_type       rsp_ff, rsp_in;

   logic [CFG_W-1:0]  d_eff;
   logic [SYN_W-1:0]  n_eff;
   logic [DATA_W-1:0] data_mask;
   logic [CODE_W-1:0] code_mask;
   logic [DATA_W-1:0] enc_data;
   logic [CODE_W-1:0] enc_cw;
   logic [SYN_W-1:0]  enc_syn;
   logic [CODE_W-1:0] chk_cw;
   logic [SYN_W-1:0]  chk_syn;
   logic              chk_unc;
   logic [CODE_W-1:0] chk_flip;
   logic [CODE_W-1:0] chk_fixed;
   logic [DATA_W-1:0] chk_data;
   logic              csr_write;

   // Scatter data bits into the non-power-of-two positions
   function automatic logic [CODE_W-1:0] scatter(input logic [DATA_W-1:0] data);
      logic [CODE_W-1:0] cw;
      int j;
      cw = '0;
      j  = 0;
      for (int pos = 1; pos <= CODE_W; pos++) begin
         if (!is_pow2(pos)) begin
            cw[pos-1] = data[j];
            j++;
         end
      end
      return cw;
   endfunction

   // Gather data bits back out of the non-power-of-two positions
   function automatic logic [DATA_W-1:0] gather(input logic [CODE_W-1:0] cw);
      logic [DATA_W-1:0] data;
      int j;
      data = '0;
      j    = 0;
      for (int pos = 1; pos <= CODE_W; pos++) begin
         if (!is_pow2(pos)) begin
            data[j] = cw[pos-1];
            j++;
         end
      end
      return data;
   endfunction

   // XOR of the positions of all set bits
   function automatic logic [SYN_W-1:0] syndrome(input logic [CODE_W-1:0] cw);
      logic [SYN_W-1:0] syn;
      syn = '0;
      for (int pos = 1; pos <= CODE_W; pos++) begin
         if (cw[pos-1]) begin
            syn = syn ^ SYN_W'(pos);
         end
      end
      return syn;
   endfunction

   // CSR access: always ready, register at word index zero
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_DATA_BITS) ?
                       CSR_DW'(data_bits_ff) : '0;

   always_comb begin
      data_bits_in = data_bits_ff;
      if (csr_write && (csr_paddr[2] == REG_DATA_BITS)) begin
         data_bits_in = csr_pwdata[CFG_W-1:0];
      end
   end

   // Never stall the requester
   assign busy = 1'b0;

   // Capture the incoming word
   assign req_valid_in = start && !busy;
   assign req_in       = req_data;

   // Clamp the data length and derive the code length
   always_comb begin
      d_eff = (data_bits_ff == '0) ? CFG_W'(1) : data_bits_ff;
      if (d_eff > DATA_MAX) begin
         d_eff = DATA_MAX;
      end
      n_eff = SYN_W'(d_eff) + SYN_W'(parity_count(d_eff));
      for (int i = 0; i < DATA_W; i++) begin
         data_mask[i] = CFG_W'(i) < d_eff;
      end
      for (int i = 0; i < CODE_W; i++) begin
         code_mask[i] = SYN_W'(i) < n_eff;
      end
   end

   // Encode: place data, then set each parity bit for even parity
   always_comb begin
      enc_data = req_ff.word[DATA_W-1:0] & data_mask;
      enc_cw   = scatter(enc_data);
      enc_syn  = syndrome(enc_cw);
      for (int k = 0; k < SYN_W; k++) begin
         enc_cw[(1 << k) - 1] = enc_syn[k];
      end
   end

   // Check: syndrome, flag beyond-code syndromes, flip the indicated bit
   always_comb begin
      chk_cw  = req_ff.word & code_mask;
      chk_syn = syndrome(chk_cw);
      chk_unc = chk_syn > n_eff;
      for (int pos = 1; pos <= CODE_W; pos++) begin
         chk_flip[pos-1] = (chk_syn == SYN_W'(pos)) && !chk_unc;
      end
      chk_fixed = chk_cw ^ chk_flip;
      chk_data  = gather(chk_fixed);
   end

   // Select the result for the action
   always_comb begin
      rsp_valid_in = req_valid_ff;
      if (req_ff.action == ACT_ENCODE) begin
         rsp_in.code_word      = enc_cw;
         rsp_in.data_word      = enc_data;
         rsp_in.error_found    = 1'b0;
         rsp_in.error_position = '0;
         rsp_in.uncorrectable  = 1'b0;
      end else begin
         rsp_in.code_word      = chk_fixed;
         rsp_in.data_word      = chk_data;
         rsp_in.error_found    = chk_syn != '0;
         rsp_in.error_position = chk_syn;
         rsp_in.uncorrectable  = chk_unc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff <= DATA_BITS_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         data_bits_ff <= data_bits_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Every accepted word yields a result on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("accepted word produced no result");

   // Beyond-code syndrome must also be flagged as an error
   a_unc_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.uncorrectable |-> rsp_data.error_found)
      else $error("uncorrectable without error_found");

   // Clean result carries a zero syndrome
   a_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.error_found |->
         rsp_data.error_position == '0 && !rsp_data.uncorrectable)
      else $error("clean word with nonzero syndrome flags");

   // Encode never reports an error
   a_encode_flags: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && req_ff.action == ACT_ENCODE |=> !rsp_data.error_found)
      else $error("encode reported an error");

endmodule
